// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the solver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PDS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pll divider solver assertion failed");

// Check that a condition implies another in the same cycle.
`define PDS_ASSERT_IMP(label, ante, cons) `PDS_ASSERT(label, (ante) |-> (cons))

`endif

// ===== hdl/pds_pkg.sv =====
// Types and constants of the PLL divider solver.
package pds_pkg;

    localparam int PDS_PRE_DIV_MAX  = 15;
    localparam int PDS_POST_DIV_MAX = 7;
    localparam int PDS_FB_DIV_MAX   = 400;

    localparam longint unsigned PLLIN_MIN_HZ = 64'd5000000;
    localparam longint unsigned PLLIN_MAX_HZ = 64'd64000000;
    localparam longint unsigned VCO_LOW_HZ   = 64'd500000000;
    localparam longint unsigned VCO_HIGH_HZ  = 64'd1600000000;
    localparam longint unsigned OUT_LIMIT_HZ = 64'd800000000;
    localparam longint unsigned FB_DIV_MIN   = 64'd16;

    localparam int WANT_W = 30;

    typedef enum logic [1:0] {
        CODE_OK      = 2'd0,
        CODE_INVALID = 2'd1,
        CODE_NOSOL   = 2'd2
    } t_code;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PRE,
        S_MULA,
        S_MULB,
        S_MULC,
        S_RANGE,
        S_DIV,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic  load;
        logic  step_pre;
        logic  step_p2;
        logic  step_p1;
        logic  mul_a;
        logic  mul_b;
        logic  mul_c;
        logic  div_init;
        logic  div_step;
        logic  set_code;
        t_code code;
        logic  res_we;
    } t_cmd;

    typedef struct packed {
        logic zero_arg;
        logic want_high;
        logic pre_ok;
        logic last_pre;
        logic last_p2;
        logic last_p1;
        logic too_big;
        logic div_last;
        logic hit;
    } t_stat;

endpackage

// ===== hdl/pds_if.sv =====
// Valid/ready channel interfaces of the PLL divider solver.
interface pds_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] reference_hz;
    logic [31:0] wanted_hz;

    modport source (output valid, output reference_hz, output wanted_hz, input ready);
    modport sink (input valid, input reference_hz, input wanted_hz, output ready);
endinterface

interface pds_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [8:0]  fb_divider;
    logic [3:0]  pre_divider;
    logic [2:0]  post_divider_one;
    logic [2:0]  post_divider_two;
    logic [29:0] achieved_hz;

    modport source (
        output valid, output status, output fb_divider, output pre_divider,
        output post_divider_one, output post_divider_two, output achieved_hz,
        input ready
    );
    modport sink (
        input valid, input status, input fb_divider, input pre_divider,
        input post_divider_one, input post_divider_two, input achieved_hz,
        output ready
    );
endinterface

// ===== hdl/pds_datapath.sv =====
// Datapath of the PLL divider solver: candidate counters, products, divider, result word.
`include "assert_macros.svh"

module pds_datapath
    import pds_pkg::*;
#(
    parameter int PRE_DIV_MAX  = PDS_PRE_DIV_MAX,
    parameter int POST_DIV_MAX = PDS_POST_DIV_MAX,
    parameter int FB_DIV_MAX   = PDS_FB_DIV_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_reference_hz,
    input  logic [31:0] i_wanted_hz,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [1:0]  o_status,
    output logic [8:0]  o_fb_divider,
    output logic [3:0]  o_pre_divider,
    output logic [2:0]  o_post_divider_one,
    output logic [2:0]  o_post_divider_two,
    output logic [29:0] o_achieved_hz
);

    localparam int PRE_W  = $clog2(PRE_DIV_MAX + 1);
    localparam int POST_W = $clog2(POST_DIV_MAX + 1);
    localparam int FB_W   = $clog2(FB_DIV_MAX + 1);
    localparam int PPA_W  = PRE_W + POST_W;
    localparam int PP_W   = PPA_W + POST_W;
    localparam int NUM_W  = WANT_W + PP_W;
    localparam int CW     = (NUM_W > 32 + FB_W) ? NUM_W : 32 + FB_W;
    localparam int CNT_W  = $clog2(FB_W);

    logic [31:0]       r_ref;
    logic [31:0]       r_want;
    logic [PRE_W-1:0]  r_pre;
    logic [POST_W-1:0] r_p2;
    logic [POST_W-1:0] r_p1;
    logic [PPA_W-1:0]  r_ppa;
    logic [PP_W-1:0]   r_pp;
    logic [NUM_W-1:0]  r_num;
    logic [31:0]       r_rem;
    logic [FB_W-1:0]   r_low;
    logic [FB_W-1:0]   r_quo;
    logic [CNT_W-1:0]  r_cnt;
    t_code             r_code;

    logic [1:0]        r_res_status;
    logic [8:0]        r_res_fb;
    logic [3:0]        r_res_pre;
    logic [2:0]        r_res_p1;
    logic [2:0]        r_res_p2;
    logic [29:0]       r_res_hz;

    logic [32:0]       n_shift;
    logic [32:0]       n_diff;
    logic [CW-1:0]     n_num_w;
    logic [CW-1:0]     n_pre_w;

    assign n_shift = {r_rem, r_low[FB_W-1]};
    assign n_diff  = n_shift - {1'b0, r_ref};
    assign n_num_w = CW'(r_num);
    assign n_pre_w = CW'(r_pre);

    always_comb begin
        o_stat.zero_arg  = (r_ref == 32'd0) || (r_want == 32'd0);
        o_stat.want_high = r_want > 32'(OUT_LIMIT_HZ);
        o_stat.pre_ok    = !((CW'(r_ref) < CW'(PLLIN_MIN_HZ) * n_pre_w)
                          || (CW'(r_ref) > CW'(PLLIN_MAX_HZ) * n_pre_w));
        o_stat.last_pre  = r_pre == PRE_W'(PRE_DIV_MAX);
        o_stat.last_p2   = r_p2 == POST_W'(POST_DIV_MAX);
        o_stat.last_p1   = r_p1 == POST_W'(POST_DIV_MAX);
        o_stat.too_big   = n_num_w >= (CW'(r_ref) << FB_W);
        o_stat.div_last  = r_cnt == CNT_W'(FB_W - 1);
        o_stat.hit       = (r_rem == 32'd0)
                        && (r_quo >= FB_W'(FB_DIV_MIN))
                        && (r_quo <= FB_W'(FB_DIV_MAX))
                        && (n_num_w >= CW'(VCO_LOW_HZ) * n_pre_w)
                        && (n_num_w <= CW'(VCO_HIGH_HZ) * n_pre_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre <= PRE_W'(1);
            r_p2  <= POST_W'(1);
            r_p1  <= POST_W'(1);
        end else if (i_cmd.load) begin
            r_pre <= PRE_W'(1);
            r_p2  <= POST_W'(1);
            r_p1  <= POST_W'(1);
        end else if (i_cmd.step_pre) begin
            r_pre <= r_pre + PRE_W'(1);
            r_p2  <= POST_W'(1);
            r_p1  <= POST_W'(1);
        end else if (i_cmd.step_p2) begin
            r_p2 <= r_p2 + POST_W'(1);
            r_p1 <= r_p2 + POST_W'(1);
        end else if (i_cmd.step_p1) begin
            r_p1 <= r_p1 + POST_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ref  <= i_reference_hz;
            r_want <= i_wanted_hz;
        end
        if (i_cmd.mul_a) begin
            r_ppa <= PPA_W'(r_pre) * PPA_W'(r_p2);
        end
        if (i_cmd.mul_b) begin
            r_pp <= PP_W'(r_ppa) * PP_W'(r_p1);
        end
        if (i_cmd.mul_c) begin
            r_num <= NUM_W'(r_want[WANT_W-1:0]) * NUM_W'(r_pp);
        end
        if (i_cmd.div_init) begin
            r_rem <= 32'(r_num >> FB_W);
            r_low <= r_num[FB_W-1:0];
            r_quo <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_low <= r_low << 1;
            r_cnt <= r_cnt + CNT_W'(1);
            if (!n_diff[32]) begin
                r_rem <= n_diff[31:0];
                r_quo <= {r_quo[FB_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift[31:0];
                r_quo <= {r_quo[FB_W-2:0], 1'b0};
            end
        end
        if (i_cmd.set_code) begin
            r_code <= i_cmd.code;
        end
        if (i_cmd.res_we) begin
            r_res_status <= r_code;
            if (r_code == CODE_OK) begin
                r_res_fb  <= 9'(r_quo);
                r_res_pre <= 4'(r_pre);
                r_res_p1  <= 3'(r_p1);
                r_res_p2  <= 3'(r_p2);
                r_res_hz  <= 30'(r_want);
            end else begin
                r_res_fb  <= '0;
                r_res_pre <= '0;
                r_res_p1  <= '0;
                r_res_p2  <= '0;
                r_res_hz  <= '0;
            end
        end
    end

    assign o_status           = r_res_status;
    assign o_fb_divider       = r_res_fb;
    assign o_pre_divider      = r_res_pre;
    assign o_post_divider_one = r_res_p1;
    assign o_post_divider_two = r_res_p2;
    assign o_achieved_hz      = r_res_hz;

    `PDS_ASSERT_IMP(a_div_rem_bound, i_cmd.div_step, r_rem < r_ref)
    `PDS_ASSERT(a_post_order, r_p1 >= r_p2)

endmodule

// ===== hdl/pds_ctrl.sv =====
// Controller of the PLL divider solver: search sequencing and result handshake.
`include "assert_macros.svh"

module pds_ctrl
    import pds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   adv_cmd;
    t_state adv_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // advance to the next candidate
    always_comb begin
        adv_cmd   = '0;
        adv_state = S_MULA;
        if (!i_stat.last_p1) begin
            adv_cmd.step_p1 = 1'b1;
        end else if (!i_stat.last_p2) begin
            adv_cmd.step_p2 = 1'b1;
        end else if (!i_stat.last_pre) begin
            adv_cmd.step_pre = 1'b1;
            adv_state        = S_PRE;
        end else begin
            adv_cmd.set_code = 1'b1;
            adv_cmd.code     = CODE_NOSOL;
            adv_state        = S_FINISH;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_stat.zero_arg) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = CODE_INVALID;
                    n_state        = S_FINISH;
                end else if (i_stat.want_high) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = CODE_NOSOL;
                    n_state        = S_FINISH;
                end else begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (i_stat.pre_ok) begin
                    n_state = S_MULA;
                end else if (i_stat.last_pre) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = CODE_NOSOL;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.step_pre = 1'b1;
                end
            end
            S_MULA: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MULB;
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_MULC;
            end
            S_MULC: begin
                o_cmd.mul_c = 1'b1;
                n_state     = S_RANGE;
            end
            S_RANGE: begin
                if (i_stat.too_big) begin
                    o_cmd   = adv_cmd;
                    n_state = adv_state;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.hit) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = CODE_OK;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd   = adv_cmd;
                    n_state = adv_state;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_we = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.res_we) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    `PDS_ASSERT_IMP(a_out_from_finish, $rose(r_out_valid), $past(r_state == S_FINISH))
    `PDS_ASSERT(a_div_to_check, (r_state == S_DIV) && i_stat.div_last |=> r_state == S_CHECK)

endmodule

// ===== hdl/pll_divider_solver.sv =====
// PLL divider solver: takes a reference and a wanted frequency in hertz and returns the first
// exact setting of pre-divider, second and first post dividers and feedback divider, searched
// in that order, with status ok, invalid argument or no solution. One word is worked at a time:
// after acceptance, a start state checks the arguments, then each pre-divider is tested for its
// input range, and each candidate (post1 >= post2) passes the multiply states, a range test and,
// if in range, the restoring divider that forms the feedback divider one bit per cycle; a finish
// state loads the output register once the last result there has been taken. With defaults the
// search space holds 420 candidates. A finished result waits in an output register while the
// next word is accepted.
module pll_divider_solver
    import pds_pkg::*;
#(
    parameter int PRE_DIV_MAX  = PDS_PRE_DIV_MAX,
    parameter int POST_DIV_MAX = PDS_POST_DIV_MAX,
    parameter int FB_DIV_MAX   = PDS_FB_DIV_MAX
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pds_in_if.sink    i_in,
    pds_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    pds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pds_datapath #(
        .PRE_DIV_MAX  (PRE_DIV_MAX),
        .POST_DIV_MAX (POST_DIV_MAX),
        .FB_DIV_MAX   (FB_DIV_MAX)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_reference_hz     (i_in.reference_hz),
        .i_wanted_hz        (i_in.wanted_hz),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_status           (o_out.status),
        .o_fb_divider       (o_out.fb_divider),
        .o_pre_divider      (o_out.pre_divider),
        .o_post_divider_one (o_out.post_divider_one),
        .o_post_divider_two (o_out.post_divider_two),
        .o_achieved_hz      (o_out.achieved_hz)
    );

endmodule
